>>> src/ccpm_pkg.sv
// Package for the CCPM swashplate mixer.
// Holds field widths, the reciprocal constant for the percentage scaling,
// the geometry codes and the register indexes. No dependencies.
package ccpm_pkg;

    localparam int CMD_W       = 10;
    localparam int MIX_W       = 8;
    localparam int SERVO_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int LANES       = 3;

    localparam int PROD_W      = CMD_W + MIX_W;
    localparam int MAG_W       = PROD_W - 1;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 23;
    localparam int RPROD_W     = MAG_W + RECIP_W;
    localparam int QUO_W       = 10;
    localparam int SCALED_W    = QUO_W + 1;

    // Rounded-up reciprocal of 100 at a scale of 2^23; exact for magnitudes below 91180.
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(83887);

    typedef logic signed [CMD_W-1:0]    cmd_t;
    typedef logic signed [MIX_W-1:0]    mix_t;
    typedef logic signed [SERVO_W-1:0]  servo_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_index_t;

    typedef enum logic [2:0] {
        PLATE_H1  = 3'd0,
        PLATE_H2  = 3'd1,
        PLATE_HE3 = 3'd2,
        PLATE_HR3 = 3'd3,
        PLATE_HN3 = 3'd4,
        PLATE_H3  = 3'd5,
        PLATE_H4  = 3'd6,
        PLATE_H4X = 3'd7
    } plate_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLATE_TYPE   = 2'd0,
        CFG_AILERON_MIX  = 2'd1,
        CFG_ELEVATOR_MIX = 2'd2,
        CFG_PITCH_MIX    = 2'd3
    } cfg_reg_t;

endpackage

>>> src/ccpm_cmd_if.sv
// Command channel interface: one item carries the three stick commands.
// Depends on ccpm_pkg.
interface ccpm_cmd_if
    import ccpm_pkg::*;
();
    logic valid;
    logic ready;
    cmd_t aileron_in;
    cmd_t elevator_in;
    cmd_t pitch_in;

    modport source (output valid, output aileron_in, output elevator_in, output pitch_in,
                    input ready);
    modport sink (input valid, input aileron_in, input elevator_in, input pitch_in,
                  output ready);
endinterface

>>> src/ccpm_servo_if.sv
// Servo channel interface: one item carries the mixed servo drive values.
// Depends on ccpm_pkg.
interface ccpm_servo_if
    import ccpm_pkg::*;
();
    logic   valid;
    logic   ready;
    servo_t aileron_servo;
    servo_t elevator_servo;
    servo_t pitch_servo;
    servo_t second_elevator_servo;
    logic   second_elevator_driven;

    modport source (output valid, output aileron_servo, output elevator_servo,
                    output pitch_servo, output second_elevator_servo,
                    output second_elevator_driven, input ready);
    modport sink (input valid, input aileron_servo, input elevator_servo,
                  input pitch_servo, input second_elevator_servo,
                  input second_elevator_driven, output ready);
endinterface

>>> src/ccpm_cfg_if.sv
// Configuration write channel interface: register index and write data.
// Depends on ccpm_pkg.
interface ccpm_cfg_if
    import ccpm_pkg::*;
();
    logic             valid;
    logic             ready;
    cfg_index_t       index;
    logic [MIX_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/swashplate_ccpm_mixer.sv
// CCPM swashplate mixer top level.
// Depends on ccpm_pkg and the interfaces ccpm_cmd_if, ccpm_servo_if and ccpm_cfg_if.
//
// The cmd channel takes one item of aileron, elevator and pitch commands. Each
// command is scaled by its signed percentage register, truncated toward zero,
// and the selected swashplate geometry mixes the three into servo values sent
// as one item on the servo channel. The cfg channel writes the geometry and the
// three mix registers; it is always ready and should only be used while no
// item is in flight. Writes take effect on the next accepted item.
//
// The datapath has four register stages: the signed command-by-percentage
// multiply, the multiply by the reciprocal of 100, the shift and sign restore,
// and the geometry sums into the output register. An accepted item passes
// through these stages in order, and one item can be accepted every cycle
// while the servo receiver takes items. When it stalls, stages fill up behind
// the output register and cmd ready drops only once every stage holds an item;
// nothing is lost or repeated. Reset clears all valid bits and sets the
// configuration registers to zero, which selects the H1 geometry with zero mix.
module swashplate_ccpm_mixer
    import ccpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ccpm_cmd_if.sink            cmd,
    ccpm_servo_if.source        servo,
    ccpm_cfg_if.sink            cfg
);

    plate_t plate_reg;
    mix_t   mix_reg [LANES];

    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    logic   adv1, adv2, adv3, adv4;

    cmd_t                       cmd_val  [LANES];
    logic signed [PROD_W-1:0]   prod     [LANES];
    logic [MAG_W-1:0]           mag_next [LANES];

    logic [MAG_W-1:0]           s1_mag_reg   [LANES];
    logic                       s1_neg_reg   [LANES];
    logic [RPROD_W-1:0]         s2_rprod_reg [LANES];
    logic                       s2_neg_reg   [LANES];
    logic signed [SCALED_W-1:0] s3_scaled_reg  [LANES];
    logic signed [SCALED_W-1:0] s3_scaled_next [LANES];

    servo_t ail_next, ele_next, pit_next, ele2_next;
    logic   drv_next;
    servo_t ail_reg, ele_reg, pit_reg, ele2_reg;
    logic   drv_reg;
    servo_t a, e, p, ha, he;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plate_reg  <= PLATE_H1;
            mix_reg[0] <= '0;
            mix_reg[1] <= '0;
            mix_reg[2] <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_PLATE_TYPE:   plate_reg  <= plate_t'(cfg.data[2:0]);
                CFG_AILERON_MIX:  mix_reg[0] <= mix_t'(cfg.data);
                CFG_ELEVATOR_MIX: mix_reg[1] <= mix_t'(cfg.data);
                CFG_PITCH_MIX:    mix_reg[2] <= mix_t'(cfg.data);
                default:          ;
            endcase
        end
    end

    assign adv4      = !v4_reg || servo.ready;
    assign adv3      = !v3_reg || adv4;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign cmd.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= cmd.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    assign cmd_val[0] = cmd.aileron_in;
    assign cmd_val[1] = cmd.elevator_in;
    assign cmd_val[2] = cmd.pitch_in;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = PROD_W'(cmd_val[i]) * PROD_W'(mix_reg[i]);
            if (prod[i][PROD_W-1])
                mag_next[i] = MAG_W'(-prod[i]);
            else
                mag_next[i] = MAG_W'(prod[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (s2_neg_reg[i])
                s3_scaled_next[i] = -$signed({1'b0, s2_rprod_reg[i][RECIP_SHIFT +: QUO_W]});
            else
                s3_scaled_next[i] = $signed({1'b0, s2_rprod_reg[i][RECIP_SHIFT +: QUO_W]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (adv1)
            begin
                s1_mag_reg[i] <= mag_next[i];
                s1_neg_reg[i] <= prod[i][PROD_W-1];
            end
            if (adv2)
            begin
                s2_rprod_reg[i] <= RPROD_W'(s1_mag_reg[i]) * RPROD_W'(RECIP_100);
                s2_neg_reg[i]   <= s1_neg_reg[i];
            end
            if (adv3)
                s3_scaled_reg[i] <= s3_scaled_next[i];
        end
    end

    always_comb
    begin
        a  = SERVO_W'(s3_scaled_reg[0]);
        e  = SERVO_W'(s3_scaled_reg[1]);
        p  = SERVO_W'(s3_scaled_reg[2]);
        ha = a >>> 1;
        he = e >>> 1;
        ele2_next = '0;
        drv_next  = 1'b0;
        case (plate_reg)
            PLATE_H2:
            begin
                ele_next = e;
                ail_next = a + p;
                pit_next = p - a;
            end
            PLATE_HE3:
            begin
                ele_next = e + p;
                ail_next = a + p;
                pit_next = p - a;
            end
            PLATE_HR3:
            begin
                ele_next = e + p;
                ail_next = a + p - he;
                pit_next = p - a - he;
            end
            PLATE_HN3:
            begin
                ele_next = e + p - ha;
                ail_next = a + p;
                pit_next = p - e - ha;
            end
            PLATE_H3:
            begin
                ele_next = e + p;
                ail_next = a + p - e;
                pit_next = p - e - a;
            end
            PLATE_H4:
            begin
                ele_next  = e + p;
                ele2_next = p - e;
                ail_next  = a + p;
                pit_next  = p - a;
                drv_next  = 1'b1;
            end
            PLATE_H4X:
            begin
                ele_next  = he - ha + p;
                ele2_next = ha - he + p;
                ail_next  = he + ha + p;
                pit_next  = p - he - ha;
                drv_next  = 1'b1;
            end
            default:
            begin
                ail_next = a;
                ele_next = e;
                pit_next = p;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            ail_reg  <= ail_next;
            ele_reg  <= ele_next;
            pit_reg  <= pit_next;
            ele2_reg <= ele2_next;
            drv_reg  <= drv_next;
        end
    end

    assign servo.valid                  = v4_reg;
    assign servo.aileron_servo          = ail_reg;
    assign servo.elevator_servo         = ele_reg;
    assign servo.pitch_servo            = pit_reg;
    assign servo.second_elevator_servo  = ele2_reg;
    assign servo.second_elevator_driven = drv_reg;

endmodule
